### hw/rtl/hsme_pkg.sv
// Shared types and constants of the half-sample mode estimator.
package hsme_pkg;

  localparam int unsigned MaxSamplesDef  = 1024;
  localparam int unsigned SampleWidthDef = 64;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned BaseW    = 12;
  localparam int unsigned PosW     = 13;
  localparam int unsigned WinSizeW = 11;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_MODE = 1'b0,
    CFG_WINDOW_SIZE = 1'b1
  } hsme_cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_SCAN,
    CMD_UPDATE,
    CMD_RD12,
    CMD_RD3,
    CMD_CMP,
    CMD_SUM,
    CMD_FINISH
  } hsme_cmd_e;

  typedef struct packed {
    logic empty;
    logic narrow_done;
    logic window_mode;
    logic scan_last;
  } hsme_sts_t;

endpackage

### hw/rtl/hsme_datapath.sv
// Datapath: sample memory, window scan, final-range selection and result registers.
module hsme_datapath import hsme_pkg::*; #(
  parameter int unsigned MaxSamples  = MaxSamplesDef,
  parameter int unsigned SampleWidth = SampleWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WinSizeW-1:0] cfg_wdata_i,
  input  logic [ValueW-1:0]   sample_value_i,
  input  logic [BaseW-1:0]    base_index_i,
  input  hsme_cmd_e           cmd_i,
  output hsme_sts_t           sts_o,
  output logic [ValueW-1:0]   mode_value_o,
  output logic [PosW-1:0]     position_first_o,
  output logic [PosW-1:0]     position_second_o,
  output logic                has_second_o,
  output logic                empty_error_o
);

  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned AddrW = $clog2(MaxSamples);
  localparam int unsigned DiffW = SampleWidth + 1;
  localparam int unsigned LimW  = (CntW > WinSizeW) ? CntW : WinSizeW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSamples);

  typedef enum logic [2:0] {
    RD_NONE,
    RD_INIT,
    RD_CAND,
    RD_X12,
    RD_X3
  } hsme_rd_kind_e;

  logic signed [SampleWidth-1:0] mem_q [MaxSamples];
  logic signed [SampleWidth-1:0] rd_a_q, rd_b_q;
  logic [CntW-1:0]               addr_a_full, addr_b_full;
  hsme_rd_kind_e                 kind_d, kind_q;
  logic [CntW-1:0]               rd_idx_q;

  logic [CntW-1:0]     cnt_q, cnt_next;
  logic [BaseW-1:0]    base_q;
  logic                wmode_q;
  logic [WinSizeW-1:0] wsize_q, lim;

  logic [CntW-1:0] s_q, e_q, n_q, i_q, best_q;
  logic [CntW-1:0] sz, half;
  logic [CntW:0]   sz_inc;
  logic signed [DiffW-1:0] bdiff_q, cand_diff;

  logic signed [SampleWidth-1:0] x1_q, x2_q, x3_q, sa, sb, avg;
  logic signed [DiffW-1:0]       d21, d32, sum_q, sum_adj;
  logic                          lt_q, eq_q;
  logic [CntW-1:0]               p1_q, p2_q, p1_d, p2_d;
  logic                          has2_q, has2_d;

  logic signed [ValueW-1:0] res_mode_q;
  logic [PosW-1:0]          res_p1_q, res_p2_q;
  logic                     res_has2_q, res_err_q;

  assign sz     = e_q - s_q;
  assign sz_inc = (CntW+1)'(sz) + (CntW+1)'(1);
  assign half   = sz_inc[CntW:1];
  assign lim    = wmode_q ? ((wsize_q == '0) ? WinSizeW'(1) : wsize_q) : WinSizeW'(3);
  assign cnt_next = (cnt_q < MaxCnt) ? cnt_q + CntW'(1) : cnt_q;

  assign cand_diff = DiffW'(rd_a_q) - DiffW'(rd_b_q);
  assign d21       = DiffW'(x2_q) - DiffW'(x1_q);
  assign d32       = DiffW'(x3_q) - DiffW'(x2_q);
  // truncate toward zero: bump odd negative sums before the shift
  assign sum_adj   = sum_q + DiffW'(sum_q[DiffW-1] & sum_q[0]);
  assign avg       = sum_adj[DiffW-1:1];

  assign sts_o.empty       = (cnt_q == '0);
  assign sts_o.narrow_done = (LimW'(sz) <= LimW'(lim));
  assign sts_o.window_mode = wmode_q;
  assign sts_o.scan_last   = ((CntW+1)'(i_q) + (CntW+1)'(n_q)) == (CntW+1)'(e_q);

  // read addresses and the tag that follows the read data
  always_comb begin
    addr_a_full = s_q;
    addr_b_full = s_q;
    kind_d      = RD_NONE;
    unique case (cmd_i)
      CMD_INIT: begin
        addr_a_full = e_q - CntW'(1);
        addr_b_full = s_q;
        kind_d      = RD_INIT;
      end
      CMD_SCAN: begin
        addr_a_full = i_q + n_q - CntW'(1);
        addr_b_full = i_q;
        kind_d      = RD_CAND;
      end
      CMD_RD12: begin
        addr_a_full = s_q;
        addr_b_full = s_q + CntW'(1);
        kind_d      = RD_X12;
      end
      CMD_RD3: begin
        addr_a_full = s_q + CntW'(2);
        kind_d      = RD_X3;
      end
      default: ;
    endcase
  end

  // final pair: single values go in doubled so the halving returns them exactly
  always_comb begin
    sa     = x1_q;
    sb     = x1_q;
    p1_d   = s_q;
    p2_d   = s_q + CntW'(1);
    has2_d = 1'b0;
    priority if (sz == CntW'(1)) begin
      sa = x1_q;
      sb = x1_q;
    end else if (sz == CntW'(2)) begin
      sb     = x2_q;
      has2_d = 1'b1;
    end else if (eq_q) begin
      sa   = x2_q;
      sb   = x2_q;
      p1_d = s_q + CntW'(1);
    end else if (lt_q) begin
      sb     = x2_q;
      has2_d = 1'b1;
    end else begin
      sa     = x2_q;
      sb     = x3_q;
      p1_d   = s_q + CntW'(1);
      p2_d   = s_q + CntW'(2);
      has2_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD && cnt_q < MaxCnt) begin
      mem_q[cnt_q[AddrW-1:0]] <= sample_value_i[SampleWidth-1:0];
    end
    rd_a_q <= mem_q[addr_a_full[AddrW-1:0]];
    rd_b_q <= mem_q[addr_b_full[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      base_q  <= '0;
      wmode_q <= 1'b0;
      wsize_q <= WinSizeW'(1);
      kind_q  <= RD_NONE;
    end else begin
      kind_q <= kind_d;
      if (cfg_we_i) begin
        unique case (hsme_cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW_MODE: wmode_q <= cfg_wdata_i[0];
          CFG_WINDOW_SIZE: wsize_q <= cfg_wdata_i;
        endcase
      end
      if (cmd_i == CMD_LOAD) begin
        if (cnt_q == '0) begin
          base_q <= base_index_i;
        end
        cnt_q <= cnt_next;
      end else if (cmd_i == CMD_FINISH) begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        s_q <= '0;
        e_q <= cnt_next;
      end
      CMD_INIT: begin
        n_q    <= half;
        i_q    <= s_q;
        best_q <= s_q;
      end
      CMD_SCAN: begin
        i_q      <= i_q + CntW'(1);
        rd_idx_q <= i_q;
      end
      CMD_UPDATE: begin
        s_q <= best_q;
        e_q <= best_q + n_q;
      end
      CMD_CMP: begin
        lt_q <= (d21 < d32);
        eq_q <= (d21 == d32);
      end
      CMD_SUM: begin
        sum_q  <= DiffW'(sa) + DiffW'(sb);
        p1_q   <= p1_d;
        p2_q   <= p2_d;
        has2_q <= has2_d;
      end
      CMD_FINISH: begin
        priority if (cnt_q == '0) begin
          res_mode_q <= '0;
          res_p1_q   <= '0;
          res_p2_q   <= '0;
          res_has2_q <= 1'b0;
          res_err_q  <= 1'b1;
        end else if (wmode_q) begin
          res_mode_q <= '0;
          res_p1_q   <= PosW'(s_q) + PosW'(base_q);
          res_p2_q   <= PosW'(e_q) + PosW'(base_q);
          res_has2_q <= 1'b1;
          res_err_q  <= 1'b0;
        end else begin
          res_mode_q <= ValueW'(avg);
          res_p1_q   <= PosW'(p1_q) + PosW'(base_q);
          res_p2_q   <= has2_q ? PosW'(p2_q) + PosW'(base_q) : '0;
          res_has2_q <= has2_q;
          res_err_q  <= 1'b0;
        end
      end
      default: ;
    endcase

    unique case (kind_q)
      RD_INIT: bdiff_q <= cand_diff;
      RD_CAND: begin
        // later window wins on equal spread
        if (cand_diff <= bdiff_q) begin
          bdiff_q <= cand_diff;
          best_q  <= rd_idx_q;
        end
      end
      RD_X12: begin
        x1_q <= rd_a_q;
        x2_q <= rd_b_q;
      end
      RD_X3:   x3_q <= rd_a_q;
      default: ;
    endcase
  end

  assign mode_value_o      = res_mode_q;
  assign position_first_o  = res_p1_q;
  assign position_second_o = res_p2_q;
  assign has_second_o      = res_has2_q;
  assign empty_error_o     = res_err_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("sample count beyond store depth");

  a_update_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_UPDATE |=> CntW'(e_q - s_q) == n_q)
    else $error("narrowed range does not match window width");

  a_cand_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == RD_CAND |->
      rd_idx_q >= s_q && ((CntW+1)'(rd_idx_q) + (CntW+1)'(n_q)) <= (CntW+1)'(e_q))
    else $error("candidate window outside current range");

endmodule

### hw/rtl/hsme_ctrl.sv
// Controller: load, narrowing passes, final-range steps and result handshake.
module hsme_ctrl import hsme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  hsme_sts_t sts_i,
  output hsme_cmd_e cmd_o
);

  typedef enum logic [10:0] {
    ST_LOAD   = 11'h001,
    ST_CHECK  = 11'h002,
    ST_SCAN   = 11'h004,
    ST_DRAIN  = 11'h008,
    ST_UPDATE = 11'h010,
    ST_RD1    = 11'h020,
    ST_RD2    = 11'h040,
    ST_WAIT3  = 11'h080,
    ST_CMP    = 11'h100,
    ST_SUM    = 11'h200,
    ST_FINISH = 11'h400
  } hsme_state_e;

  hsme_state_e state_d, state_q;
  logic        out_valid_d, out_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        // a closing beat waits until the previous result is taken
        in_ready_o = !(in_last_i && out_valid_q);
        if (in_valid_i && in_ready_o) begin
          cmd_o = CMD_LOAD;
          if (in_last_i) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        priority if (sts_i.empty || (sts_i.narrow_done && sts_i.window_mode)) begin
          state_d = ST_FINISH;
        end else if (sts_i.narrow_done) begin
          state_d = ST_RD1;
        end else begin
          cmd_o   = CMD_INIT;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o = CMD_SCAN;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: begin
        cmd_o   = CMD_UPDATE;
        state_d = ST_CHECK;
      end
      ST_RD1: begin
        cmd_o   = CMD_RD12;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        cmd_o   = CMD_RD3;
        state_d = ST_WAIT3;
      end
      ST_WAIT3:  state_d = ST_CMP;
      ST_CMP: begin
        cmd_o   = CMD_CMP;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o   = CMD_SUM;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o   = CMD_FINISH;
        state_d = ST_LOAD;
      end
      default:   state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (state_q == ST_FINISH) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> !out_valid_q)
    else $error("result register still occupied at finish");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> out_valid_o)
    else $error("finish did not raise out_valid");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_last_i |=> state_q == ST_CHECK)
    else $error("closing beat did not start processing");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && !sts_i.scan_last |=> state_q == ST_SCAN)
    else $error("scan left before its last candidate");

endmodule

### hw/rtl/half_sample_mode_estimator_unit.sv
// Load: one sample beat per cycle. After the closing beat, each narrowing pass over s samples
// runs a check, floor(s/2) + 1 window compares, a drain and an update. A final check then steps
// in full mode through two reads, a wait, a compare and a sum to the finish, or in window mode
// goes straight to the finish, before out_valid_o rises. A closing beat waits while a result is held.
// Reset clears the count, base latch, configuration and handshake state; the sample store is not
// cleared and holds stale data until written.
module half_sample_mode_estimator_unit import hsme_pkg::*; #(
  parameter int unsigned MaxSamples  = MaxSamplesDef,
  parameter int unsigned SampleWidth = SampleWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WinSizeW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ValueW-1:0]   sample_value_i,
  input  logic [BaseW-1:0]    base_index_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ValueW-1:0]   mode_value_o,
  output logic [PosW-1:0]     position_first_o,
  output logic [PosW-1:0]     position_second_o,
  output logic                has_second_o,
  output logic                empty_error_o
);

  hsme_cmd_e cmd;
  hsme_sts_t sts;

  hsme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hsme_datapath #(
    .MaxSamples  (MaxSamples),
    .SampleWidth (SampleWidth)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sample_value_i    (sample_value_i),
    .base_index_i      (base_index_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_value_o      (mode_value_o),
    .position_first_o  (position_first_o),
    .position_second_o (position_second_o),
    .has_second_o      (has_second_o),
    .empty_error_o     (empty_error_o)
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench of the half-sample mode estimator: directed sets, backpressure, random sets.
module tb_top;
  import hsme_pkg::*;

  typedef enum int {
    SHAPE_STEPS,
    SHAPE_CLUSTER,
    SHAPE_SPREAD,
    SHAPE_FLAT,
    SHAPE_SHUFFLED
  } set_shape_e;

  typedef struct packed {
    logic [ValueW-1:0] mode;
    logic [PosW-1:0]   first;
    logic [PosW-1:0]   second;
    logic              has_second;
    logic              empty;
  } hsm_estimate_t;

  localparam logic [ValueW-1:0] ValMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] ValMin = 64'h8000_0000_0000_0000;
  localparam logic signed [65:0] AccMax = 66'sh0_7FFF_FFFF_FFFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  hsme_cfg_idx_e       cfg_idx_i = CFG_WINDOW_MODE;
  logic [WinSizeW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [ValueW-1:0]   sample_value_i = '0;
  logic [BaseW-1:0]    base_index_i = '0;
  logic                last_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ValueW-1:0]   mode_value_o;
  logic [PosW-1:0]     position_first_o;
  logic [PosW-1:0]     position_second_o;
  logic                has_second_o;
  logic                empty_error_o;

  half_sample_mode_estimator_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_value_i    (sample_value_i),
    .base_index_i      (base_index_i),
    .last_i            (last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .mode_value_o      (mode_value_o),
    .position_first_o  (position_first_o),
    .position_second_o (position_second_o),
    .has_second_o      (has_second_o),
    .empty_error_o     (empty_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [ValueW-1:0] held_samples [MaxSamplesDef];
  int unsigned              held_count = 0;
  logic [BaseW-1:0]         held_base = '0;
  logic                     pred_window_mode = 1'b0;
  logic [WinSizeW-1:0]      pred_window_size = 11'd1;
  hsm_estimate_t            estimate_q[$];

  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          send_idle_pct = 11;
  int          recv_idle_pct = 74;
  int          hold_off_left = 0;
  bit          hold_off_req = 1'b0;
  logic [ValueW-1:0] set_vals[$];

  // exact difference, one bit wider than the samples
  function automatic logic signed [ValueW:0] spread(input logic signed [ValueW-1:0] hi,
                                                    input logic signed [ValueW-1:0] lo);
    return $signed({hi[ValueW-1], hi}) - $signed({lo[ValueW-1], lo});
  endfunction

  function automatic logic [ValueW-1:0] half_sum(input logic [ValueW-1:0] a,
                                                 input logic [ValueW-1:0] b);
    logic signed [ValueW:0] sum;
    sum = $signed({a[ValueW-1], a}) + $signed({b[ValueW-1], b});
    return ValueW'(sum / 65'sd2);
  endfunction

  function automatic hsm_estimate_t estimate_set();
    hsm_estimate_t            r;
    int unsigned              s, e, sz, lim, n, best, p1, p2;
    logic signed [ValueW-1:0] wa, wb, x1, x2, x3;
    logic signed [ValueW:0]   lgap, rgap;
    r = '0;
    if (held_count == 0) begin
      r.empty = 1'b1;
      return r;
    end
    s = 0;
    e = held_count;
    p1 = 0;
    p2 = 0;
    lim = pred_window_mode ? ((pred_window_size != 0) ? pred_window_size : 1) : 3;
    sz = e - s;
    while (sz > lim) begin
      n = sz / 2 + sz % 2;
      best = s;
      wa = held_samples[e - 1];
      wb = held_samples[s];
      // later windows win ties; a window wider than the whole range never wins
      for (int unsigned i = s; i + n <= e; i++) begin
        if (spread(held_samples[i + n - 1], held_samples[i]) <= spread(wa, wb)) begin
          wa = held_samples[i + n - 1];
          wb = held_samples[i];
          best = i;
        end
      end
      s = best;
      e = s + n;
      sz = e - s;
    end
    if (pred_window_mode) begin
      p1 = s;
      p2 = e;
      r.has_second = 1'b1;
    end else if (sz == 1) begin
      r.mode = held_samples[s];
      p1 = s;
    end else if (sz == 2) begin
      r.mode = half_sum(held_samples[s], held_samples[s + 1]);
      p1 = s;
      p2 = s + 1;
      r.has_second = 1'b1;
    end else begin
      x1 = held_samples[s];
      x2 = held_samples[s + 1];
      x3 = held_samples[s + 2];
      lgap = spread(x2, x1);
      rgap = spread(x3, x2);
      if (lgap == rgap) begin
        r.mode = x2;
        p1 = s + 1;
      end else if (lgap < rgap) begin
        r.mode = half_sum(x1, x2);
        p1 = s;
        p2 = s + 1;
        r.has_second = 1'b1;
      end else begin
        r.mode = half_sum(x2, x3);
        p1 = s + 1;
        p2 = s + 2;
        r.has_second = 1'b1;
      end
    end
    r.first = PosW'(p1 + held_base);
    r.second = r.has_second ? PosW'(p2 + held_base) : '0;
    return r;
  endfunction

  // track accepted beats and register writes
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (held_count == 0) held_base = base_index_i;
      if (held_count < MaxSamplesDef) begin
        held_samples[held_count] = sample_value_i;
        held_count++;
      end
      if (last_i) begin
        estimate_q.push_back(estimate_set());
        held_count = 0;
      end
    end
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_MODE: pred_window_mode = cfg_wdata_i[0];
        CFG_WINDOW_SIZE: pred_window_size = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_estimates
    hsm_estimate_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.mode = mode_value_o;
      got.first = position_first_o;
      got.second = position_second_o;
      got.has_second = has_second_o;
      got.empty = empty_error_o;
      if (estimate_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: mode %0d first %0d", $signed(got.mode), got.first);
      end else begin
        want = estimate_q.pop_front();
        if (got.mode !== want.mode || got.first !== want.first || got.second !== want.second ||
            got.has_second !== want.has_second || got.empty !== want.empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch exp/act: mode %0d/%0d first %0d/%0d second %0d/%0d",
                      " has2 %b/%b empty %b/%b"},
                     $signed(want.mode), $signed(got.mode), want.first, got.first,
                     want.second, got.second, want.has_second, got.has_second,
                     want.empty, got.empty);
        end
      end
    end
  end

  // result side: random stalls, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_left = 400;
      hold_off_req = 1'b0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_beat(input logic [ValueW-1:0] value, input logic [BaseW-1:0] base,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_value_i <= value;
    base_index_i <= base;
    last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // only the first beat's base counts; the rest carry noise
  task automatic send_set_vals(input logic [BaseW-1:0] base);
    for (int k = 0; k < set_vals.size(); k++)
      send_beat(set_vals[k], (k == 0) ? base : BaseW'($urandom), k == set_vals.size() - 1);
  endtask

  task automatic send_shaped_set(input int size, input set_shape_e shape);
    logic signed [65:0] acc;
    logic [ValueW-1:0]  start, incr, v;
    set_vals.delete();
    start = {$urandom, $urandom};
    if (shape == SHAPE_SPREAD || $urandom_range(7) == 0) start = ValMin;
    acc = $signed({{2{start[ValueW-1]}}, start});
    for (int k = 0; k < size; k++) begin
      case (shape)
        SHAPE_STEPS:   incr = ValueW'($urandom_range(3));
        SHAPE_CLUSTER: incr = ($urandom_range(5) == 0) ? ({$urandom, $urandom} >> $urandom_range(63))
                                                        : ValueW'($urandom_range(2));
        SHAPE_SPREAD:  incr = {$urandom, $urandom} >> $urandom_range(12, 2);
        default:       incr = '0;
      endcase
      if (shape == SHAPE_SHUFFLED) begin
        v = {$urandom, $urandom};
        if ($urandom_range(1)) v = {{60{v[3]}}, v[3:0]};
        set_vals.push_back(v);
      end else begin
        if (k != 0) begin
          acc = acc + $signed({2'b00, incr});
          if (acc > AccMax) acc = AccMax;
        end
        set_vals.push_back(ValueW'(acc));
      end
    end
    send_set_vals(BaseW'($urandom));
  endtask

  task automatic wait_for_estimates();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (estimate_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [WinSizeW-1:0] size);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WINDOW_MODE;
    cfg_wdata_i <= WinSizeW'(mode);
    @(posedge clk_i);
    cfg_idx_i <= CFG_WINDOW_SIZE;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_full_mode_rules();
    set_config(1'b0, 11'd1);
    set_vals = '{ValMax};
    send_set_vals(12'd0);
    set_vals = '{ValMin, ValMax};              // average rounds toward zero
    send_set_vals(12'hFFF);
    set_vals = '{ValMin, ValMin};
    send_set_vals(12'd17);
    set_vals = '{-64'sd5, 64'd0, 64'd5};       // equal gaps
    send_set_vals(12'd100);
    set_vals = '{-64'sd3, -64'sd2, 64'd100};   // left gap smaller, negative odd sum
    send_set_vals(12'h800);
    set_vals = '{64'd0, 64'd90, 64'd91};       // right gap smaller
    send_set_vals(12'd3);
    set_vals = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5};
    send_set_vals(12'hFFE);
    set_vals = '{64'd10, 64'd5, 64'd0, -64'sd5}; // descending: first window kept
    send_set_vals(12'd1);
    wait_for_estimates();
  endtask

  task automatic test_window_mode_limits();
    set_config(1'b1, 11'd0);                   // zero size acts as one
    set_vals = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd100};
    send_set_vals(12'hFFF);
    wait_for_estimates();
    set_config(1'b1, 11'h7FF);
    set_vals = '{ValMin, 64'd0, ValMax};
    send_set_vals(12'd42);
    wait_for_estimates();
  endtask

  task automatic test_output_backpressure();
    set_config(1'b0, 11'd1);
    hold_off_req = 1'b1;
    for (int k = 0; k < 6; k++) send_shaped_set(4, SHAPE_STEPS);
    wait_for_estimates();
  endtask

  task automatic test_store_overflow();
    send_shaped_set(MaxSamplesDef + 3, SHAPE_CLUSTER);
    wait_for_estimates();
  endtask

  task automatic test_random_traffic(input int beats, input int send_pct, input int recv_pct);
    int                  chunk_end, size, pick;
    logic [WinSizeW-1:0] wsize;
    set_shape_e          shape;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      wait_for_estimates();
      case ($urandom_range(5))
        0:       wsize = 11'd0;
        1:       wsize = 11'd1;
        2:       wsize = 11'd1024;
        3:       wsize = 11'h7FF;
        default: wsize = WinSizeW'($urandom_range(12, 2));
      endcase
      set_config(1'($urandom_range(1)), wsize);
      chunk_end = beats_sent + beats / 3;
      while (beats_sent < chunk_end) begin
        size = ($urandom_range(11) == 0) ? $urandom_range(150, 25) : $urandom_range(24, 1);
        pick = $urandom_range(19);
        if (pick < 7) shape = SHAPE_STEPS;
        else if (pick < 12) shape = SHAPE_CLUSTER;
        else if (pick < 15) shape = SHAPE_SPREAD;
        else if (pick < 16) shape = SHAPE_FLAT;
        else shape = SHAPE_SHUFFLED;
        send_shaped_set(size, shape);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_mode_rules();
    test_window_mode_limits();
    test_output_backpressure();
    test_store_overflow();
    test_random_traffic(75, 11, 74);
    test_random_traffic(75, 74, 11);
    test_random_traffic(75, 0, 0);
    wait_for_estimates();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && estimate_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
